// ----- rtl/core/minv_pkg.sv -----
// Shared constants and cofactor index tables for the 3x3 inverse pipeline.
package minv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int N_ENT         = 9;        // matrix entries
  localparam int N_ROW         = 3;
  localparam int ENT_W         = 32;
  localparam int PROD_W        = 2 * ENT_W;
  localparam int CF_W          = 64;       // cofactor, signed
  localparam int TERM_W        = 97;       // entry * cofactor, signed
  localparam int DET_W         = 98;       // determinant, signed
  localparam int DMAG_W        = 97;       // determinant magnitude
  localparam int QB            = 33;       // quotient bits kept before saturation
  localparam int FRONT_STAGES  = 6;
  localparam int DIV_STAGES    = QB + 1;
  localparam int N_STAGES      = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [ENT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [ENT_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef logic [3:0] idx_t;
  typedef idx_t idx_tab_t [N_ENT];
  typedef idx_t row_tab_t [N_ROW];

  // cofactor i = m[PA_A]*m[PA_B] - m[PB_A]*m[PB_B]
  localparam idx_tab_t PA_A = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam idx_tab_t PA_B = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam idx_tab_t PB_A = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam idx_tab_t PB_B = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // cofactors that pair with the first row in the determinant expansion
  localparam row_tab_t DET_COF = '{4'd0, 4'd3, 4'd6};

endpackage

// ----- rtl/core/minv_front.sv -----
// Front pipeline: products, cofactors, determinant and divider operands.
module minv_front import minv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int NUM_W     = CF_W + 2 * FRAC_BITS
) (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  logic signed [ENT_W-1:0] m [N_ENT],
  output logic [NUM_W-1:0]        num [N_ENT],
  output logic [N_ENT-1:0]        qneg,
  output logic [DMAG_W-1:0]       dmag,
  output logic                    zero
);

  logic signed [PROD_W-1:0] pa [N_ENT];
  logic signed [PROD_W-1:0] pb [N_ENT];
  logic signed [ENT_W-1:0]  e0 [N_ROW];
  logic signed [ENT_W-1:0]  e1 [N_ROW];
  logic signed [CF_W-1:0]   c1 [N_ENT];
  logic signed [CF_W-1:0]   c2 [N_ENT];
  logic signed [CF_W-1:0]   c3 [N_ENT];
  logic signed [CF_W-1:0]   c4 [N_ENT];
  logic signed [PROD_W-1:0] ph [N_ROW];
  logic signed [PROD_W:0]   pl [N_ROW];
  logic signed [TERM_W-1:0] t  [N_ROW];
  logic signed [DET_W-1:0]  det;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < N_ENT; i++) begin
        pa[i] <= m[PA_A[i]] * m[PA_B[i]];
        pb[i] <= m[PB_A[i]] * m[PB_B[i]];
      end
      for (int k = 0; k < N_ROW; k++) e0[k] <= m[k];
    end
    if (en[1]) begin
      for (int i = 0; i < N_ENT; i++) c1[i] <= pa[i] - pb[i];
      e1 <= e0;
    end
    // split the 32x64 product into two 32x32 partial products (upper and lower cofactor halves)
    if (en[2]) begin
      for (int k = 0; k < N_ROW; k++) begin
        ph[k] <= e1[k] * $signed(c1[DET_COF[k]][CF_W-1:ENT_W]);
        pl[k] <= e1[k] * $signed({1'b0, c1[DET_COF[k]][ENT_W-1:0]});
      end
      c2 <= c1;
    end
    if (en[3]) begin
      for (int k = 0; k < N_ROW; k++)
        t[k] <= $signed({ph[k][PROD_W-1], ph[k], {ENT_W{1'b0}}})
              + $signed({{(TERM_W-PROD_W-1){pl[k][PROD_W]}}, pl[k]});
      c3 <= c2;
    end
    if (en[4]) begin
      det <= DET_W'(t[0]) + DET_W'(t[1]) + DET_W'(t[2]);
      c4  <= c3;
    end
    if (en[5]) begin
      zero <= (det == '0);
      dmag <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
      for (int i = 0; i < N_ENT; i++) begin
        num[i]  <= NUM_W'(c4[i][CF_W-1] ? CF_W'(-c4[i]) : CF_W'(c4[i])) << (2 * FRAC_BITS);
        qneg[i] <= c4[i][CF_W-1] ^ det[DET_W-1];
      end
    end
  end

endmodule

// ----- rtl/core/minv_div_lane.sv -----
// One divider lane: restoring division, one quotient bit per stage.
module minv_div_lane import minv_pkg::*; #(
  parameter int NUM_W = CF_W + 2 * FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num_in,
  input  logic                  neg_in,
  input  logic [DMAG_W-1:0]     dmag_in,
  input  logic [DMAG_W-1:0]     dmag_pipe [QB],
  output logic [QB-1:0]         q,
  output logic                  ovf,
  output logic                  neg
);

  localparam int CW = (NUM_W > DMAG_W) ? NUM_W : DMAG_W;

  logic [NUM_W-1:0] rem   [DIV_STAGES];
  logic [QB-1:0]    qr    [DIV_STAGES];
  logic             ovf_r [DIV_STAGES];
  logic             neg_r [DIV_STAGES];

  // quotient of 2^QB or more saturates whatever its sign
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]   <= num_in;
      qr[0]    <= '0;
      ovf_r[0] <= CW'(num_in >> QB) >= CW'(dmag_in);
      neg_r[0] <= neg_in;
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_step
    localparam int SH = QB - j;
    logic          take;
    logic [NUM_W-1:0] sub;

    always_comb begin
      take = CW'(rem[j-1] >> SH) >= CW'(dmag_pipe[j-1]);
      sub  = NUM_W'(CW'(dmag_pipe[j-1]) << SH);
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j]   <= take ? rem[j-1] - sub : rem[j-1];
        qr[j]    <= {qr[j-1][QB-2:0], take};
        ovf_r[j] <= ovf_r[j-1];
        neg_r[j] <= neg_r[j-1];
      end
    end
  end

  assign q   = qr[DIV_STAGES-1];
  assign ovf = ovf_r[DIV_STAGES-1];
  assign neg = neg_r[DIV_STAGES-1];

endmodule

// ----- rtl/core/minv_merge.sv -----
// Merge stage: sign, saturate and singular override for all nine lanes.
module minv_merge import minv_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [QB-1:0]    q [N_ENT],
  input  logic [N_ENT-1:0] ovf,
  input  logic [N_ENT-1:0] neg,
  input  logic             zero,
  output logic [ENT_W-1:0] inv [N_ENT],
  output logic             singular
);

  logic [ENT_W-1:0] res [N_ENT];

  always_comb begin
    for (int i = 0; i < N_ENT; i++) begin
      if (zero) begin
        res[i] = '0;
      end else if (neg[i]) begin
        if (ovf[i] || q[i] > QB'(SAT_MIN)) res[i] = SAT_MIN;
        else                               res[i] = ENT_W'(-q[i]);
      end else begin
        if (ovf[i] || q[i] > QB'(SAT_MAX)) res[i] = SAT_MAX;
        else                               res[i] = ENT_W'(q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv      <= res;
      singular <= zero;
    end
  end

endmodule

// ----- rtl/core/matrix_3x3_inverse.sv -----
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
//  channel | signals                          | word
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, m00..m22     | one matrix, nine Q16.16
//  out     | out_valid, out_ready, inv00..22, | nine inverse entries, Q16.16,
//          | singular                         | plus the zero-determinant flag
//
// One word enters per cycle while out_ready is high; there are six front stages
// (products, cofactors, split determinant products, terms, sum, operands),
// 34 divider stages (overflow check plus one quotient bit each), one merge.
// Each of nine divider lanes runs beside the others; the merge stage saturates.
// Reset (rst, synchronous) clears only the stage valid bits.
// Stalls: each stage holds while it is full and the next one holds, so bubbles
// collapse and in_ready drops only when all 41 stages are full.
module matrix_3x3_inverse import minv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
  output logic        singular
);

  localparam int NUM_W = CF_W + 2 * FRAC_BITS;
  localparam int MERGE = N_STAGES - 1;

  logic [N_STAGES-1:0] v;     // stage valid bits
  logic [N_STAGES:0]   en;    // stage load enables

  logic signed [ENT_W-1:0] m [N_ENT];
  logic [NUM_W-1:0]        num [N_ENT];
  logic [N_ENT-1:0]        qneg;
  logic [DMAG_W-1:0]       dmag;
  logic                    zero;
  logic [DMAG_W-1:0]       dmag_pipe [QB];
  logic                    zero_pipe [DIV_STAGES];
  logic [QB-1:0]           lq [N_ENT];
  logic [N_ENT-1:0]        lovf;
  logic [N_ENT-1:0]        lneg;
  logic [ENT_W-1:0]        inv [N_ENT];

  assign m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[N_STAGES] = out_ready;
    for (int k = N_STAGES - 1; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[MERGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < N_STAGES; k++)
        if (en[k]) v[k] <= v[k-1];
    end
  end

  minv_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
    .clk  (clk),
    .en   (en[FRONT_STAGES-1:0]),
    .m    (m),
    .num  (num),
    .qneg (qneg),
    .dmag (dmag),
    .zero (zero)
  );

  // divisor and singular flag travel beside the lanes, shared by all nine
  always_ff @(posedge clk) begin
    if (en[FRONT_STAGES]) begin
      zero_pipe[0] <= zero;
      dmag_pipe[0] <= dmag;
    end
    for (int k = 1; k < DIV_STAGES; k++)
      if (en[FRONT_STAGES+k]) zero_pipe[k] <= zero_pipe[k-1];
    for (int k = 1; k < QB; k++)
      if (en[FRONT_STAGES+k]) dmag_pipe[k] <= dmag_pipe[k-1];
  end

  for (genvar i = 0; i < N_ENT; i++) begin : g_lane
    minv_div_lane #(.NUM_W(NUM_W)) u_lane (
      .clk       (clk),
      .en        (en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
      .num_in    (num[i]),
      .neg_in    (qneg[i]),
      .dmag_in   (dmag),
      .dmag_pipe (dmag_pipe),
      .q         (lq[i]),
      .ovf       (lovf[i]),
      .neg       (lneg[i])
    );
  end

  minv_merge u_merge (
    .clk      (clk),
    .en       (en[MERGE]),
    .q        (lq),
    .ovf      (lovf),
    .neg      (lneg),
    .zero     (zero_pipe[DIV_STAGES-1]),
    .inv      (inv),
    .singular (singular)
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> inv00 == 0 && inv11 == 0 && inv22 == 0 && inv01 == 0)
    else $error("singular word carries nonzero entries");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && v[0] == 1'b0 |-> in_ready)
    else $error("input stalled with empty head and tail");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted word lost in first stage");

endmodule
